// ===== rtl/core/max_gap_after_cut_insertion_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the largest gap after cut insertion block.
// Each macro expands to one labeled concurrent assertion that reports by
// $error.
// ----------------------------------------------------------------------------
`ifndef MAX_GAP_AFTER_CUT_INSERTION_DEFINES_SVH
`define MAX_GAP_AFTER_CUT_INSERTION_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define MGCI_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define MGCI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MGCI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mgci_pkg.sv =====
// ----------------------------------------------------------------------------
// mgci_pkg
// Shared constants, codes and types of the largest gap after cut insertion
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgci_pkg;

   localparam int DATA_W     = 32;
   localparam int HALF_W     = DATA_W - 1;
   localparam int MAX_POINTS = 1024;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_TAIL,
      ST_COMMIT,
      ST_DONE
   } state_type;

   // Control of the shared gap unit.
   typedef struct packed {
      logic              init;
      logic              feed;
      logic [DATA_W-1:0] value;
   } gap_ctl_type;

endpackage

// ===== rtl/core/max_gap_after_cut_insertion.sv =====
// ----------------------------------------------------------------------------
// max_gap_after_cut_insertion
// Keeps the cut points of a segment sorted and returns half of the largest
// gap between neighboring points, the segment ends included.
//
//   channel  ports   direction  beat
//   request  req_*   in         one cut position
//   response rsp_*   out        half of the largest gap and a status code
//   csr      csr_*   in         new segment length, starts a new segment
//
// A rejected position or position zero goes from the check state straight to
// the result, and a repeated point ends the pass at the index where it is found.
// An insert makes one pass over the point RAM that shifts the tail up by one
// and feeds every point through the shared gap unit, one read port access per
// cycle, then feeds the segment length and commits the largest gap. After the
// result is issued the block returns to idle and takes the next request.
// Reset clears the point count; the point RAM needs no clearing pass.
// A new request is taken while the previous result waits on rsp_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_gap_after_cut_insertion_defines.svh"

module max_gap_after_cut_insertion (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mgci_pkg::DATA_W-1:0] req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mgci_pkg::HALF_W-1:0] rsp_half_max_gap,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_we,
   input  logic [mgci_pkg::DATA_W-1:0] csr_wdata
);
   import mgci_pkg::*;

   state_type         state_ff;
   state_type         state_in;

   logic [DATA_W-1:0] length_ff;
   logic [DATA_W-1:0] length_in;
   logic [DATA_W-1:0] gap_ff;
   logic [DATA_W-1:0] gap_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] pos_ff;
   logic [DATA_W-1:0] pos_in;
   logic [CNT_W-1:0]  eval_ff;
   logic [CNT_W-1:0]  eval_in;
   logic              inserted_ff;
   logic              inserted_in;
   logic [DATA_W-1:0] carry_ff;
   logic [DATA_W-1:0] carry_in;
   logic [1:0]        status_ff;
   logic [1:0]        status_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [HALF_W-1:0] rsp_half_ff;
   logic [HALF_W-1:0] rsp_half_in;
   logic [1:0]        rsp_status_ff;
   logic [1:0]        rsp_status_in;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   gap_ctl_type       gap_ctl;
   logic [DATA_W-1:0] gap_best;

   logic [CNT_W-1:0]  eval_next;
   logic              at_end;
   logic              out_range;
   logic              store_full;
   logic              is_dup;
   logic              slot_free;
   logic              req_fire;

   assign eval_next  = eval_ff + CNT_W'(1);
   assign at_end     = (eval_ff == count_ff);
   assign out_range  = (pos_ff >= length_ff);
   assign store_full = (count_ff == CNT_W'(MAX_POINTS));
   assign is_dup     = !at_end && !inserted_ff && (ram_rdata == pos_ff);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;

   mgci_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_POINTS)
   ) u_points (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mgci_gap_unit u_gap (
      .clock (clock),
      .ctl   (gap_ctl),
      .best  (gap_best)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (out_range || store_full || (pos_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (at_end) begin
               state_in = ST_TAIL;
            end else if (is_dup) begin
               state_in = ST_DONE;
            end
         end
         ST_TAIL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      ram_we        = 1'b0;
      ram_waddr     = eval_ff[IDX_W-1:0];
      ram_wdata     = pos_ff;
      ram_raddr     = eval_next[IDX_W-1:0];
      gap_ctl.init  = 1'b0;
      gap_ctl.feed  = 1'b0;
      gap_ctl.value = ram_rdata;
      length_in     = length_ff;
      gap_in        = gap_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      eval_in       = eval_ff;
      inserted_in   = inserted_ff;
      carry_in      = carry_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_half_in   = rsp_half_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in = req_position;
            end
         end
         ST_CHECK: begin
            ram_raddr    = '0;
            gap_ctl.init = 1'b1;
            eval_in      = '0;
            inserted_in  = 1'b0;
            priority if (out_range) begin
               status_in = STATUS_RANGE;
            end else if (store_full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_OK;
            end
         end
         ST_SCAN: begin
            eval_in = eval_next;
            if (at_end) begin
               // The last slot gets the carried point, or the new one if it
               // lies above every stored point.
               ram_we        = 1'b1;
               ram_wdata     = inserted_ff ? carry_ff : pos_ff;
               gap_ctl.feed  = 1'b1;
               gap_ctl.value = ram_wdata;
            end else if (inserted_ff) begin
               ram_we        = 1'b1;
               ram_wdata     = carry_ff;
               gap_ctl.feed  = 1'b1;
               gap_ctl.value = carry_ff;
               carry_in      = ram_rdata;
            end else if (ram_rdata < pos_ff) begin
               gap_ctl.feed  = 1'b1;
               gap_ctl.value = ram_rdata;
            end else if (!is_dup) begin
               ram_we        = 1'b1;
               ram_wdata     = pos_ff;
               gap_ctl.feed  = 1'b1;
               gap_ctl.value = pos_ff;
               carry_in      = ram_rdata;
               inserted_in   = 1'b1;
            end
         end
         ST_TAIL: begin
            gap_ctl.feed  = 1'b1;
            gap_ctl.value = length_ff;
            count_in      = count_ff + CNT_W'(1);
         end
         ST_COMMIT: begin
            gap_in = gap_best;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_half_in   = gap_ff[DATA_W-1:1];
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         length_in = csr_wdata;
         gap_in    = csr_wdata;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= DATA_W'(1);
         gap_ff       <= DATA_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         gap_ff       <= gap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      eval_ff       <= eval_in;
      inserted_ff   <= inserted_in;
      carry_ff      <= carry_in;
      status_ff     <= status_in;
      rsp_half_ff   <= rsp_half_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_half_max_gap = rsp_half_ff;
   assign rsp_status       = rsp_status_ff;

   `MGCI_ASSERT_IMPLY(a_write_in_scan, clock, reset, ram_we, state_ff == ST_SCAN,
      "point RAM written outside the insertion pass")
   `MGCI_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_POINTS),
      "point count beyond the store depth")
   `MGCI_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_SCAN,
      eval_ff <= count_ff, "insertion pass ran past the stored points")
   `MGCI_ASSERT_NEXT(a_count_hold, clock, reset, (state_ff != ST_TAIL) && !csr_we,
      $stable(count_ff), "point count changed without an insert")
   `MGCI_ASSERT_NEXT(a_dup_no_write, clock, reset, (state_ff == ST_SCAN) && is_dup,
      (state_ff == ST_DONE) && $stable(count_ff), "repeated point changed the store")

endmodule

// ===== rtl/core/mgci_ram.sv =====
// ----------------------------------------------------------------------------
// mgci_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgci_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/mgci_gap_unit.sv =====
// ----------------------------------------------------------------------------
// mgci_gap_unit
// Shared subtract and compare unit. Points are fed in ascending order, one
// per cycle, and the unit keeps the largest distance between neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgci_gap_unit (
   input  logic                        clock,
   input  mgci_pkg::gap_ctl_type       ctl,
   output logic [mgci_pkg::DATA_W-1:0] best
);
   import mgci_pkg::*;

   logic [DATA_W-1:0] prev_ff;
   logic [DATA_W-1:0] prev_in;
   logic [DATA_W-1:0] best_ff;
   logic [DATA_W-1:0] best_in;
   logic [DATA_W-1:0] diff;

   assign diff = ctl.value - prev_ff;

   always_comb begin
      prev_in = prev_ff;
      best_in = best_ff;
      if (ctl.init) begin
         prev_in = '0;
         best_in = '0;
      end else if (ctl.feed) begin
         prev_in = ctl.value;
         if (diff > best_ff) begin
            best_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of max_gap_after_cut_insertion. Cut positions go in on the
// request channel and a scoreboard predicts half of the largest gap and the
// status of every beat, then compares each response beat field by field.
// Directed cases come first, then random segments of several lengths under
// three idling mixes, a long response stall, and a short closing segment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import mgci_pkg::*;

   localparam logic [DATA_W-1:0] LEN_MAX     = 32'hFFFF_FFFF;
   localparam int                CYCLE_LIMIT = 8_000_000;
   localparam int                MODE_ITEMS  = 165;

   typedef struct packed {
      logic [HALF_W-1:0] half_gap;
      logic [1:0]        status;
   } gap_result_type;

   // Keeps its own sorted copy of the cuts and the queue of predicted beats.
   class gap_scoreboard;
      logic [DATA_W-1:0] seg_length;
      logic [DATA_W-1:0] cuts[$];
      logic [DATA_W-1:0] widest;
      gap_result_type    expected_gaps[$];
      int unsigned       mismatches;

      function new();
         seg_length  = 1;
         widest      = 1;
         mismatches  = 0;
      endfunction

      function void set_length(logic [DATA_W-1:0] len);
         seg_length = len;
         widest     = len;
         cuts.delete();
      endfunction

      function gap_result_type insert_cut(logic [DATA_W-1:0] pos);
         gap_result_type    res;
         int                slot;
         logic [DATA_W-1:0] prev;
         logic [DATA_W-1:0] span;
         res.status = STATUS_OK;
         if (pos >= seg_length) begin
            res.status = STATUS_RANGE;
         end else if (cuts.size() >= MAX_POINTS) begin
            res.status = STATUS_FULL;
         end else if (pos != 0) begin
            slot = 0;
            while (slot < cuts.size() && cuts[slot] < pos) slot++;
            // A repeated cut leaves the store and the largest gap alone.
            if (slot == cuts.size() || cuts[slot] != pos) begin
               cuts.insert(slot, pos);
               widest = 0;
               prev   = 0;
               foreach (cuts[k]) begin
                  span = cuts[k] - prev;
                  if (span > widest) widest = span;
                  prev = cuts[k];
               end
               span = seg_length - prev;
               if (span > widest) widest = span;
            end
         end
         res.half_gap = widest[DATA_W-1:1];
         return res;
      endfunction

      function void note_request(logic [DATA_W-1:0] pos);
         expected_gaps.insert(expected_gaps.size(), insert_cut(pos));
      endfunction

      task report_mismatch(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(logic [HALF_W-1:0] half_gap, logic [1:0] status);
         gap_result_type want;
         if (expected_gaps.size() == 0) begin
            report_mismatch($sformatf("response beat with none expected, half %0d status %0d",
                                      half_gap, status));
            return;
         end
         want = expected_gaps.pop_front();
         if (half_gap !== want.half_gap)
            report_mismatch($sformatf("half_max_gap %0d, expected %0d",
                                      half_gap, want.half_gap));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [DATA_W-1:0] req_position;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [HALF_W-1:0] rsp_half_max_gap;
   logic [1:0]        rsp_status;
   logic              csr_we;
   logic [DATA_W-1:0] csr_wdata;

   gap_scoreboard sb;
   int            sender_idle_pct   = 0;
   int            receiver_idle_pct = 0;
   int            hold_left         = 0;
   int            cycle_count       = 0;

   max_gap_after_cut_insertion dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_half_max_gap (rsp_half_max_gap),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one cut position, with random idle cycles ahead of it, and
   // returns at the edge where the beat is taken.
   task send_position(logic [DATA_W-1:0] pos);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      sb.note_request(pos);
   endtask

   task wait_all_answered();
      req_valid <= 1'b0;
      while (sb.expected_gaps.size() != 0) @(posedge clock);
   endtask

   // A new length is only written once the block has answered everything.
   task write_length(logic [DATA_W-1:0] len);
      wait_all_answered();
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_length(len);
   endtask

   task run_segment(int count);
      logic [DATA_W-1:0] len;
      logic [DATA_W-1:0] pos;
      logic [DATA_W-1:0] sent[$];
      case ($urandom_range(9))
         0:       len = $urandom();
         1:       len = LEN_MAX;
         2:       len = 1;
         3:       len = $urandom_range(3, 0);
         8, 9:    len = $urandom_range(4096, 65);
         default: len = $urandom_range(64, 2);
      endcase
      write_length(len);
      repeat (count) begin
         case ($urandom_range(19))
            0:       pos = 0;
            1:       pos = (len == 0) ? 0 : len - 1;
            2, 3:    pos = (sent.size() == 0) ? $urandom()
                                              : sent[$urandom_range(sent.size() - 1)];
            4:       pos = $urandom_range(LEN_MAX, len);
            5:       pos = $urandom();
            default: pos = (len == 0) ? $urandom() : $urandom_range(len - 1, 0);
         endcase
         sent.insert(sent.size(), pos);
         send_position(pos);
      end
   endtask

   // Response side: takes beats with random stalls, or holds off entirely
   // while hold_left counts down.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && rsp_ready) sb.check_response(rsp_half_max_gap, rsp_status);
            if (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin
      int mode;
      int sent_items;
      int seg_items;
      sb           = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_position <= '0;
      rsp_ready    <= 1'b0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed cases, starting from the length left by reset.
      sender_idle_pct   = 28;
      receiver_idle_pct = 76;
      send_position(0);
      send_position(1);
      send_position(LEN_MAX);
      write_length(0);
      send_position(0);
      write_length(LEN_MAX);
      send_position(0);
      send_position(LEN_MAX - 1);
      send_position(LEN_MAX);
      send_position(1);
      send_position(32'h8000_0000);
      send_position(32'h8000_0000);
      send_position(32'h7FFF_FFFF);
      send_position(32'h5555_5555);
      send_position(32'hAAAA_AAAA);
      write_length(10);
      send_position(5);
      send_position(5);
      send_position(3);
      send_position(9);
      send_position(10);
      send_position(1);
      send_position(0);

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct   = 28;
               receiver_idle_pct = 76;
            end
            1: begin
               sender_idle_pct   = 76;
               receiver_idle_pct = 28;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         sent_items = 0;
         while (sent_items < MODE_ITEMS) begin
            seg_items = $urandom_range(40, 4);
            run_segment(seg_items);
            sent_items += seg_items;
         end
      end

      // Long response stall while requests keep coming, so the input backs up.
      write_length(200);
      hold_left = 400;
      repeat (12) send_position($urandom_range(199, 1));

      // A short segment closes the run.
      write_length(3);
      send_position(2);
      send_position(2);
      send_position(1);
      send_position(0);
      send_position(3);

      wait_all_answered();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
